@@ rtl/annulus_polygon_point_generator_unit_assert.svh @@
// Assertion macros shared by the checker of the annulus point generator.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ANNULUS_POLYGON_POINT_GENERATOR_UNIT_ASSERT_SVH
`define ANNULUS_POLYGON_POINT_GENERATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define APG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define APG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/apg_pkg.sv @@
// Shared types, widths and constants of the annulus point generator.
// No dependencies; every RTL module imports this package.
package apg_pkg;

	localparam int CNT_W      = 10;
	localparam int RAD_W      = 23;
	localparam int CTR_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GUARD_BITS = 16;
	localparam int GAIN_W     = 30;
	localparam int PROD_W     = RAD_W + GAIN_W;
	localparam int DW         = RAD_W + GUARD_BITS + 3;
	localparam int ATAN_N     = 24;

	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'h26DD3B6A;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INNER_COUNT  = 3'd0,
		CFG_OUTER_COUNT  = 3'd1,
		CFG_INNER_RADIUS = 3'd2,
		CFG_OUTER_RADIUS = 3'd3,
		CFG_CENTER_X     = 3'd4,
		CFG_CENTER_Y     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic                 done;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} rot_res_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turns32(input logic [4:0] idx);
		logic [31:0] t;
		unique case (idx)
			5'd0:  t = 32'h20000000;
			5'd1:  t = 32'h12E4051E;
			5'd2:  t = 32'h09FB385B;
			5'd3:  t = 32'h051111D4;
			5'd4:  t = 32'h028B0D43;
			5'd5:  t = 32'h0145D7E1;
			5'd6:  t = 32'h00A2F61E;
			5'd7:  t = 32'h00517C55;
			5'd8:  t = 32'h0028BE53;
			5'd9:  t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30;
			5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3;
			5'd23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/apg_divider.sv @@
// Iterative restoring divider that forms the node angle (k << ANGLE_BITS) / count.
// Depends on apg_pkg; one quotient bit per cycle on a shared subtractor.
module apg_divider import apg_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CNT_W-1:0]      node_k,
	input  logic [CNT_W-1:0]      divisor,
	output logic                  done,
	output logic [ANGLE_BITS-1:0] quotient
);

	localparam int NS  = CNT_W + ANGLE_BITS;
	localparam int SCW = $clog2(NS + 1);

	logic           busy_q;
	logic           done_q;
	logic [SCW-1:0] step_q;
	logic [NS-1:0]  dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [ANGLE_BITS-1:0] quo_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [CNT_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, dvd_q[NS-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
		rem_n = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SCW'(1);
			if (step_q == SCW'(NS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {node_k, {ANGLE_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NS-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[ANGLE_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/apg_cordic.sv @@
// Iterative rotation-mode CORDIC: radius times (cos, sin) of a binary-turn angle.
// Depends on apg_pkg; one micro-rotation per cycle through a shared add/shift unit.
module apg_cordic import apg_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RAD_W-1:0]      radius,
	input  logic [ANGLE_BITS-1:0] angle,
	output rot_res_t              res
);

	localparam int NSTG = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
	localparam int IW   = $clog2(NSTG);
	localparam int ZW   = ANGLE_BITS + 2;
	localparam logic signed [ZW-1:0] HALF    = ZW'(2 ** (ANGLE_BITS - 1));
	localparam logic signed [ZW-1:0] QUARTER = ZW'(2 ** (ANGLE_BITS - 2));
	localparam logic [PROD_W-1:0] X0_RND = PROD_W'(2 ** (29 - GUARD_BITS));
	localparam logic [32:0] STEP_RND = 33'(2 ** (31 - ANGLE_BITS));

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_ITER = 3'b010,
		C_NEG  = 3'b100
	} cstate_t;

	cstate_t              state_q;
	logic [IW-1:0]        idx_q;
	logic                 done_q;
	logic [PROD_W-1:0]    prod_q;
	logic signed [DW-1:0] x_q;
	logic signed [DW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic                 neg_q;

	logic signed [DW-1:0] x0;
	logic signed [ZW-1:0] z0;
	logic signed [ZW-1:0] zf;
	logic                 negf;
	logic [32:0]          stp_w;
	logic signed [ZW-1:0] stp;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	always_comb begin
		x0 = signed'(DW'((prod_q + X0_RND) >> (30 - GUARD_BITS)));
		z0 = signed'({{2{angle[ANGLE_BITS-1]}}, angle});
		zf   = z0;
		negf = 1'b0;
		if (z0 > QUARTER) begin
			zf   = z0 - HALF;
			negf = 1'b1;
		end else if (z0 < -QUARTER) begin
			zf   = z0 + HALF;
			negf = 1'b1;
		end
		stp_w = ({1'b0, atan_turns32(5'(idx_q))} + STEP_RND) >> (32 - ANGLE_BITS);
		stp   = signed'(ZW'(stp_w));
		dx    = y_q >>> idx_q;
		dy    = x_q >>> idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_ITER;
						idx_q   <= '0;
					end
				end
				C_ITER: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == IW'(NSTG - 1)) begin
						state_q <= C_NEG;
					end
				end
				C_NEG: begin
					state_q <= C_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(radius) * PROD_W'(GAIN_Q30);
		if (state_q == C_IDLE && start) begin
			x_q   <= x0;
			y_q   <= '0;
			z_q   <= zf;
			neg_q <= negf;
		end else if (state_q == C_ITER) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - stp;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + stp;
			end
		end else if (state_q == C_NEG && neg_q) begin
			x_q <= -x_q;
			y_q <= -y_q;
		end
	end

	assign res.done = done_q;
	assign res.x    = x_q;
	assign res.y    = y_q;

endmodule

@@ rtl/annulus_polygon_point_generator_unit.sv @@
// Annulus outline generator: request, node sequencing, angle and rotation units.
// Depends on apg_pkg, apg_divider and apg_cordic.
//
// Each beat accepted on the request channel (req_valid/req_ready, payload
// restart) yields exactly one node beat on the point channel
// (point_valid/point_ready). The polygon is inner_count+1 nodes on the inner
// circle counting upward in angle, then outer_count+1 nodes on the outer
// circle counting downward; a count of zero acts as one and a count above
// MAX_NODES acts as MAX_NODES. last_node marks the final outer node. A
// request with restart set begins again at inner node zero. A request passes
// through the load, divide, angle, rotate and finish states: the bit-serial
// angle divider forms the node angle and the one-step-per-cycle rotation
// unit turns the radius by it. One request is in flight at a time; the block
// returns to idle, ready for the next one, as the point is loaded. The result
// sits in an output register: the next request is taken while it waits, and
// a stalled receiver only holds back the finish of the following node. Reset
// loads the default configuration and starts at inner node zero. The
// configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
module annulus_polygon_point_generator_unit import apg_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_BITS    = 24,
	parameter int MAX_NODES     = 1023
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         restart,
	output logic                         point_valid,
	input  logic                         point_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         on_outer,
	output logic [CNT_W-1:0]             node_index,
	output logic                         last_node
);

	localparam int SUM_W = 34;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam logic signed [DW-1:0] OUT_RND = DW'(2 ** (GUARD_BITS - 1));

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_DIV  = 6'b000100,
		S_ANG  = 6'b001000,
		S_ROT  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]       inner_count_q;
	logic [CNT_W-1:0]       outer_count_q;
	logic [RAD_W-1:0]       inner_radius_q;
	logic [RAD_W-1:0]       outer_radius_q;
	logic signed [CTR_W-1:0] center_x_q;
	logic signed [CTR_W-1:0] center_y_q;

	logic [CNT_W-1:0] node_cnt_q;
	logic             ring_sel_q;

	logic [CNT_W-1:0]      item_k_q;
	logic                  item_ring_q;
	logic                  item_last_q;
	logic [CNT_W-1:0]      item_cnt_q;
	logic [RAD_W-1:0]      item_radius_q;
	logic [ANGLE_BITS-1:0] angle_q;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic                         outer_q;
	logic [CNT_W-1:0]             index_q;
	logic                         last_q;

	logic             accept;
	logic             ring_cur;
	logic [CNT_W-1:0] k_cur;
	logic [CNT_W-1:0] cnt_raw;
	logic [CNT_W-1:0] cnt_eff;
	logic             wrap;
	logic             out_free;

	logic                  div_done;
	logic [ANGLE_BITS-1:0] div_quot;
	rot_res_t              rot;

	function automatic logic signed [COORD_BITS-1:0] finish_coord(
		input logic signed [DW-1:0]    v,
		input logic signed [CTR_W-1:0] c
	);
		logic signed [DW-1:0]    r;
		logic signed [SUM_W-1:0] s;
		r = (v + OUT_RND) >>> GUARD_BITS;
		s = SUM_W'(r) + SUM_W'(c);
		if (s > SAT_HI) begin
			s = SAT_HI;
		end else if (s < SAT_LO) begin
			s = SAT_LO;
		end
		return COORD_BITS'(s);
	endfunction

	always_comb begin
		accept   = req_valid && req_ready;
		ring_cur = restart ? 1'b0 : ring_sel_q;
		k_cur    = restart ? '0 : node_cnt_q;
		cnt_raw  = ring_cur ? outer_count_q : inner_count_q;
		cnt_eff  = cnt_raw;
		if (cnt_raw == '0) begin
			cnt_eff = CNT_W'(1);
		end else if ({2'b00, cnt_raw} > 12'(MAX_NODES)) begin
			cnt_eff = CNT_W'(MAX_NODES);
		end
		wrap     = (k_cur >= cnt_eff);
		out_free = !out_valid_q || point_ready;
	end

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_count_q  <= CNT_W'(16);
			outer_count_q  <= CNT_W'(16);
			inner_radius_q <= RAD_W'(256);
			outer_radius_q <= RAD_W'(512);
			center_x_q     <= '0;
			center_y_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INNER_COUNT:  inner_count_q  <= cfg_wdata[CNT_W-1:0];
				CFG_OUTER_COUNT:  outer_count_q  <= cfg_wdata[CNT_W-1:0];
				CFG_INNER_RADIUS: inner_radius_q <= cfg_wdata[RAD_W-1:0];
				CFG_OUTER_RADIUS: outer_radius_q <= cfg_wdata[RAD_W-1:0];
				CFG_CENTER_X:     center_x_q     <= signed'(cfg_wdata[CTR_W-1:0]);
				CFG_CENTER_Y:     center_y_q     <= signed'(cfg_wdata[CTR_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			node_cnt_q  <= '0;
			ring_sel_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (point_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOAD;
						if (wrap) begin
							ring_sel_q <= !ring_cur;
							node_cnt_q <= '0;
						end else begin
							ring_sel_q <= ring_cur;
							node_cnt_q <= k_cur + CNT_W'(1);
						end
					end
				end
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ANG;
					end
				end
				S_ANG: state_q <= S_ROT;
				S_ROT: begin
					if (rot.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_k_q      <= k_cur;
			item_ring_q   <= ring_cur;
			item_last_q   <= ring_cur && wrap;
			item_cnt_q    <= cnt_eff;
			item_radius_q <= ring_cur ? outer_radius_q : inner_radius_q;
		end
		if (state_q == S_DIV && div_done) begin
			angle_q <= item_ring_q ? (ANGLE_BITS'(0) - div_quot) : div_quot;
		end
		if (state_q == S_FIN && out_free) begin
			px_q    <= finish_coord(rot.x, center_x_q);
			py_q    <= finish_coord(rot.y, center_y_q);
			outer_q <= item_ring_q;
			index_q <= item_k_q;
			last_q  <= item_last_q;
		end
	end

	apg_divider #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_LOAD),
		.node_k  (item_k_q),
		.divisor (item_cnt_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	apg_cordic #(
		.ANGLE_BITS   (ANGLE_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_ANG),
		.radius(item_radius_q),
		.angle (angle_q),
		.res   (rot)
	);

	assign point_valid = out_valid_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign on_outer    = outer_q;
	assign node_index  = index_q;
	assign last_node   = last_q;

endmodule

@@ rtl/apg_checker.sv @@
// Port-level checker of the annulus point generator and its bind statement.
// Depends on apg_pkg and the assertion macro header.
`include "annulus_polygon_point_generator_unit_assert.svh"

module apg_checker import apg_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         point_valid,
	input logic                         point_ready,
	input logic signed [COORD_BITS-1:0] point_x,
	input logic signed [COORD_BITS-1:0] point_y,
	input logic                         on_outer,
	input logic [CNT_W-1:0]             node_index,
	input logic                         last_node
);

	// A stalled node beat keeps its coordinates and node index.
	`APG_ASSERT_NEXT(a_point_hold, point_valid && !point_ready, point_valid && $stable(point_x) && $stable(point_y) && $stable(node_index), "stalled point beat changed")

	// Only one request is worked on at a time.
	`APG_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

	// The closing node always lies on the outer circle.
	`APG_ASSERT_SAME(a_last_outer, point_valid && last_node, on_outer, "last node on inner circle")

	// The closing node follows at least one outer node.
	`APG_ASSERT_SAME(a_last_index, point_valid && last_node, node_index != '0, "last node at index zero")

endmodule

bind annulus_polygon_point_generator_unit apg_checker #(
	.COORD_BITS(COORD_BITS)
) u_apg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.point_valid(point_valid),
	.point_ready(point_ready),
	.point_x    (point_x),
	.point_y    (point_y),
	.on_outer   (on_outer),
	.node_index (node_index),
	.last_node  (last_node)
);
